FILE: sv/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

	localparam int DATA_W        = 32;
	localparam int KIND_W        = 2;
	localparam int DEPTH_DEFAULT = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_POP     = 2'd0,
		KIND_FLUSH   = 2'd1,
		KIND_REFUSED = 2'd2
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic  load;      // capture input transfer
		logic  rd_next;   // read entry below top
		logic  push;      // write newcomer on top
		logic  pop;       // drop top, take read data as new top
		logic  emit;      // load output register
		logic  emit_top;  // 1: top entry, 0: newcomer
		kind_t kind;
		logic  last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_zero;
		logic cnt_one;
		logic cnt_full;
		logic top_ge_v;
		logic next_lt_v;
		logic eos;
		logic out_free;
	} status_t;

endpackage

FILE: sv/msp_if.sv
`timescale 1ns / 1ps

interface msp_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [msp_pkg::DATA_W-1:0] value;
	logic                             end_of_sequence;

	modport source (output valid, value, end_of_sequence, input ready);
	modport sink (input valid, value, end_of_sequence, output ready);
endinterface

interface msp_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [msp_pkg::DATA_W-1:0] out_value;
	logic        [msp_pkg::KIND_W-1:0] kind;
	logic                             last;

	modport source (output valid, out_value, kind, last, input ready);
	modport sink (input valid, out_value, kind, last, output ready);
endinterface

FILE: sv/msp_ram.sv
`timescale 1ns / 1ps

module msp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

FILE: sv/msp_ctrl.sv
`timescale 1ns / 1ps

module msp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  msp_pkg::status_t st,
	output msp_pkg::cmd_t    cmd
);

	import msp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_POP,
		S_REFUSE,
		S_FLUSH_RD,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd      = '0;
		cmd.kind = KIND_POP;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CMP;
				end
			end
			S_CMP: begin
				if (!st.cnt_zero && st.top_ge_v) begin
					cmd.rd_next = !st.cnt_one;
					state_d     = S_POP;
				end else if (!st.cnt_full) begin
					cmd.push = 1'b1;
					state_d  = st.eos ? S_FLUSH_RD : S_IDLE;
				end else begin
					state_d = S_REFUSE;
				end
			end
			S_POP: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_top = 1'b1;
					cmd.pop      = 1'b1;
					cmd.kind     = KIND_POP;
					cmd.last     = !st.eos && (st.cnt_one || st.next_lt_v);
					state_d      = S_CMP;
				end
			end
			S_REFUSE: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_REFUSED;
					cmd.last = !st.eos;
					state_d  = st.eos ? S_FLUSH_RD : S_IDLE;
				end
			end
			S_FLUSH_RD: begin
				cmd.rd_next = !st.cnt_one;
				state_d     = S_FLUSH;
			end
			S_FLUSH: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_top = 1'b1;
					cmd.pop      = 1'b1;
					cmd.kind     = KIND_FLUSH;
					cmd.last     = st.cnt_one;
					state_d      = st.cnt_one ? S_IDLE : S_FLUSH_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a flush is only entered with something on the stack
	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH_RD) |-> !st.cnt_zero)
		else $error("flush entered on empty stack");

	// a last result returns to idle, or to the compare that pushes the newcomer
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == S_IDLE || state_q == S_CMP))
		else $error("last result without return to idle");

	a_pop_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> $past(state_q == S_CMP) || $past(state_q == S_POP))
		else $error("pop without compare");

endmodule

FILE: sv/msp_dp.sv
`timescale 1ns / 1ps

module msp_dp #(
	parameter int DEPTH = msp_pkg::DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [msp_pkg::DATA_W-1:0] in_value,
	input  logic                              in_eos,
	input  msp_pkg::cmd_t                     cmd,
	output msp_pkg::status_t                  st,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [msp_pkg::DATA_W-1:0] out_value,
	output logic        [msp_pkg::KIND_W-1:0] out_kind,
	output logic                              out_last
);

	import msp_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [DATA_W-1:0] value_q;
	logic                     eos_q;
	logic signed [DATA_W-1:0] top_q;
	logic        [CW-1:0]     count_q;
	logic        [CW-1:0]     below;
	logic        [DATA_W-1:0] rdata;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic        [KIND_W-1:0] out_kind_q;
	logic                     out_last_q;

	assign below = count_q - CW'(2);

	msp_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (cmd.push),
		.waddr  (count_q[AW-1:0]),
		.wdata  (value_q),
		.re     (cmd.rd_next),
		.raddr  (below[AW-1:0]),
		.rdata_q(rdata)
	);

	always_comb begin
		st.cnt_zero  = (count_q == '0);
		st.cnt_one   = (count_q == CW'(1));
		st.cnt_full  = (count_q == CW'(DEPTH));
		st.top_ge_v  = (top_q >= value_q);
		st.next_lt_v = ($signed(rdata) < value_q);
		st.eos       = eos_q;
		st.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= in_value;
			eos_q   <= in_eos;
		end
		if (cmd.push) begin
			top_q <= value_q;
		end else if (cmd.pop) begin
			top_q <= $signed(rdata);
		end
		if (cmd.emit) begin
			out_value_q <= cmd.emit_top ? top_q : value_q;
			out_kind_q  <= cmd.kind;
			out_last_q  <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_kind  = out_kind_q;
	assign out_last  = out_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("stack count out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (count_q != CW'(DEPTH)))
		else $error("push on full stack");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (count_q != '0))
		else $error("pop on empty stack");

endmodule

FILE: sv/monotonic_stack_popper.sv
`timescale 1ns / 1ps

// Monotonic increasing stack popper.
// in_ch (sink): one transfer carries value and end_of_sequence. Each newcomer
//   pops and reports, top first, every stored value >= it (kind 0), is then
//   pushed, or reported with kind 2 if the stack is still full. With
//   end_of_sequence set the whole stack is flushed top first (kind 1).
// out_ch (source): one transfer per result; last marks the final result
//   caused by an input item. Items that cause no result give no transfer.
// Steps: the input transfer in the idle state, a compare state, then per popped
//   or flushed entry a stack RAM read, then an output load, and an output load
//   for a refusal. An item that is only pushed returns to idle after the
//   compare; no new input is taken before the controller is done with the last
//   item. Entry pops are bound by the single read port of the stack RAM and the
//   registered read.
// Stall: results sit in one output register; while out_ch.ready is low the
//   controller holds before its next result and accepts further input
//   transfers only until one of them causes a result, nothing is lost.
// Reset (arst_n low): stack empty, output register empty, controller idle.
module monotonic_stack_popper #(
	parameter int DEPTH = msp_pkg::DEPTH_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	msp_in_if.sink       in_ch,
	msp_out_if.source    out_ch
);

	import msp_pkg::*;

	cmd_t    cmd;
	status_t st;

	msp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.st      (st),
		.cmd     (cmd)
	);

	msp_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_value (in_ch.value),
		.in_eos   (in_ch.end_of_sequence),
		.cmd      (cmd),
		.st       (st),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_value(out_ch.out_value),
		.out_kind (out_ch.kind),
		.out_last (out_ch.last)
	);

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import msp_pkg::*;

	localparam int DEPTH       = DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS = 286;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		kind_t                    kind;
		logic                     last;
	} result_t;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     eos;
		bit                       typed;
		bit                       has_res;
		result_t                  res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	msp_in_if  in_ch ();
	msp_out_if out_ch ();

	monotonic_stack_popper #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic signed [DATA_W-1:0] stack_model [DEPTH];
	int        stack_fill;
	result_t   pending_results [$];
	stim_row_t dir_rows [$];

	int  cycle_count;
	int  items_sent;
	int  results_seen;
	int  pops_seen;
	int  flushes_seen;
	int  refusals_seen;
	int  mismatches;
	int  hold_left;
	int  holds_done;
	bit  calm;
	result_t want;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void stack_step(input logic signed [DATA_W-1:0] v, input logic eos,
		input bit record);
		result_t batch [$];
		while (stack_fill > 0 && stack_model[stack_fill-1] >= v) begin
			stack_fill--;
			batch.push_back('{stack_model[stack_fill], KIND_POP, 1'b0});
		end
		if (stack_fill < DEPTH) begin
			stack_model[stack_fill] = v;
			stack_fill++;
		end else begin
			batch.push_back('{v, KIND_REFUSED, 1'b0});
		end
		if (eos) begin
			while (stack_fill > 0) begin
				stack_fill--;
				batch.push_back('{stack_model[stack_fill], KIND_FLUSH, 1'b0});
			end
		end
		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		if (record)
			foreach (batch[i]) pending_results.push_back(batch[i]);
	endfunction

	function automatic void add_row(input logic signed [DATA_W-1:0] v, input logic eos,
		input bit typed, input bit has_res, input result_t res);
		stim_row_t r;
		r.value   = v;
		r.eos     = eos;
		r.typed   = typed;
		r.has_res = has_res;
		r.res     = res;
		dir_rows.push_back(r);
	endfunction

	task automatic send_item(input logic signed [DATA_W-1:0] v, input logic eos);
		int gap;
		gap = 0;
		while (!calm && $urandom_range(0, 99) < 11)
			gap++;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.value           <= v;
		in_ch.end_of_sequence <= eos;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("testbench: FAIL");
			$finish;
		end
	end

	// output side: check each transfer, random stalls plus long hold-offs
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			case (out_ch.kind)
				KIND_POP:     pops_seen++;
				KIND_FLUSH:   flushes_seen++;
				KIND_REFUSED: refusals_seen++;
				default:      ;
			endcase
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %0d kind %0d last %0d",
						out_ch.out_value, out_ch.kind, out_ch.last);
			end else begin
				want = pending_results[0];
				pending_results.delete(0);
				if (out_ch.out_value !== want.val || out_ch.kind !== want.kind ||
					out_ch.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: value %0d/%0d kind %0d/%0d last %0d/%0d (exp/got)",
							want.val, out_ch.out_value, want.kind, out_ch.kind,
							want.last, out_ch.last);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (arst_n && holds_done < 2 &&
			results_seen >= (holds_done == 0 ? 40 : 250)) begin
			hold_left = HOLD_CYCLES;
			holds_done++;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm || $urandom_range(0, 99) >= 11;
		end
	end

	initial begin
		int  n_rand;
		int  run_kind;
		int  run_len;
		int  base;
		logic signed [DATA_W-1:0] v;
		logic eos;

		clk          = 1'b0;
		arst_n       = 1'b0;
		out_ch.ready = 1'b0;
		in_ch.valid           <= 1'b0;
		in_ch.value           <= '0;
		in_ch.end_of_sequence <= 1'b0;
		stack_fill    = 0;
		cycle_count   = 0;
		items_sent    = 0;
		results_seen  = 0;
		pops_seen     = 0;
		flushes_seen  = 0;
		refusals_seen = 0;
		mismatches    = 0;
		hold_left     = 0;
		holds_done    = 0;
		calm          = 1'b0;

		// value, eos, typed, has typed result, typed result
		add_row(32'sd5, 1'b0, 1'b1, 1'b0, '0);
		add_row(32'sd5, 1'b0, 1'b1, 1'b1, '{32'sd5, KIND_POP, 1'b1});
		add_row(VAL_MAX, 1'b0, 1'b1, 1'b0, '0);
		add_row(VAL_MIN, 1'b1, 1'b0, 1'b0, '0);
		add_row(32'sd0, 1'b1, 1'b1, 1'b1, '{32'sd0, KIND_FLUSH, 1'b1});
		for (int i = 0; i < DEPTH; i++)
			add_row(i - DEPTH / 2, 1'b0, 1'b0, 1'b0, '0);
		add_row(32'sd100, 1'b0, 1'b1, 1'b1, '{32'sd100, KIND_REFUSED, 1'b1});
		add_row(32'sd200, 1'b1, 1'b0, 1'b0, '0);
		add_row(VAL_MIN, 1'b1, 1'b1, 1'b1, '{VAL_MIN, KIND_FLUSH, 1'b1});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].value, dir_rows[i].eos);
			if (dir_rows[i].typed) begin
				stack_step(dir_rows[i].value, dir_rows[i].eos, 1'b0);
				if (dir_rows[i].has_res)
					pending_results.push_back(dir_rows[i].res);
			end else begin
				stack_step(dir_rows[i].value, dir_rows[i].eos, 1'b1);
			end
		end

		n_rand = 0;
		while (n_rand < RANDOM_ITEMS) begin
			run_kind = $urandom_range(0, 9);
			run_len  = $urandom_range(1, 24);
			base     = int'($urandom_range(0, 200)) - 100;
			for (int k = 0; k < run_len && n_rand < RANDOM_ITEMS; k++) begin
				if (run_kind < 2) begin
					v   = $urandom;
					eos = ($urandom_range(0, 7) == 0);
				end else begin
					if ($urandom_range(0, 19) == 0) begin
						v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
					end else if (run_kind < 6) begin
						if ($urandom_range(0, 9) == 0) begin
							v = base - int'($urandom_range(0, 20));
						end else begin
							base = base + int'($urandom_range(0, 3));
							v    = base;
						end
					end else begin
						v = int'($urandom_range(0, 16)) - 8;
					end
					eos = (k == run_len - 1) || ($urandom_range(0, 39) == 0);
				end
				calm = (n_rand >= 120 && n_rand < 200);
				send_item(v, eos);
				stack_step(v, eos, 1'b1);
				n_rand++;
			end
		end
		in_ch.valid <= 1'b0;
		calm = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input transfers (%0d directed) and %0d results:",
			items_sent, dir_rows.size(), results_seen);
		$display("  %0d pops, %0d flushes, %0d refusals, %0d long output hold-offs, %0d mismatches",
			pops_seen, flushes_seen, refusals_seen, holds_done, mismatches);
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
